### sv/display_reply_frame_decoder_unit_assert.svh
// Assertion macros shared by the reply frame decoder RTL.
// Expects signals named clk and arst_n in the module that expands them.
`ifndef DISPLAY_REPLY_FRAME_DECODER_UNIT_ASSERT_SVH
`define DISPLAY_REPLY_FRAME_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DRFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
`define DRFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
`else
`define DRFD_ASSERT(lbl, prop)
`define DRFD_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### sv/drfd_pkg.sv
// Types and constants of the reply frame decoder.
// No dependencies; used by every module of the block.
package drfd_pkg;

	localparam logic [7:0] TERM_BYTE   = 8'hFF;
	localparam logic [7:0] HEAD_TOUCH  = 8'h65;
	localparam logic [7:0] HEAD_PAGE   = 8'h66;
	localparam logic [7:0] HEAD_STRING = 8'h70;
	localparam logic [7:0] HEAD_NUMBER = 8'h71;
	localparam logic [7:0] HEAD_DONE   = 8'h01;

	localparam logic [7:0] EV_PUSH    = 8'h01;
	localparam logic [7:0] EV_RELEASE = 8'h00;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_PUSH = 2'd1;
	localparam logic [1:0] ACT_POP  = 2'd2;

	// Text characters emitted for one string frame at most.
	localparam logic [4:0] MAX_TEXT = 5'd31;

	// Header bytes kept in flops: head plus four payload bytes.
	localparam int HDR_BYTES = 5;

	typedef enum logic [2:0] {
		KIND_REG   = 3'd0,
		KIND_TOUCH = 3'd1,
		KIND_PAGE  = 3'd2,
		KIND_TEXT  = 3'd3,
		KIND_NUM   = 3'd4,
		KIND_DONE  = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] page;
		logic [7:0] component;
		logic       push;
		logic       pop;
	} entry_t;

	typedef struct packed {
		logic [7:0] head;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} hdr_t;

	typedef struct packed {
		kind_t       kind;
		logic        accepted;
		logic        found;
		logic [1:0]  touch_action;
		logic [5:0]  object_index;
		logic [7:0]  page;
		logic [7:0]  component;
		logic [7:0]  event_code;
		logic [31:0] number;
		logic [7:0]  text_char;
		logic        last;
	} result_t;

endpackage

### sv/drfd_frame_buf.sv
// Frame collector: terminator tracking, header flops and the frame byte memory.
// Depends on drfd_pkg and the assertion macro header.
`include "display_reply_frame_decoder_unit_assert.svh"

module drfd_frame_buf #(
	parameter int FRAME_BYTES = 32,
	localparam int BW = $clog2(FRAME_BYTES),
	localparam int FW = $clog2(FRAME_BYTES + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_we,
	input  logic [7:0]     rx_byte,
	input  logic           frame_clear,
	input  logic [BW-1:0]  rd_addr,
	output logic           frame_done,
	output drfd_pkg::hdr_t hdr,
	output logic [7:0]     rd_char
);

	localparam int HDR_LEN = drfd_pkg::HDR_BYTES;

	logic [1:0]    run_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    hdr_q [HDR_LEN];
	logic [7:0]    mem [FRAME_BYTES];
	logic [7:0]    rd_data_q;
	logic          rd_ok_q;
	logic          is_term;
	logic          store;

	assign is_term    = rx_byte == drfd_pkg::TERM_BYTE;
	assign frame_done = byte_we && is_term && run_q == 2'd2;
	assign store      = byte_we && !is_term && run_q == 2'd0 && fill_q < FW'(FRAME_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			fill_q <= '0;
			for (int i = 0; i < HDR_LEN; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (frame_clear) begin
			fill_q <= '0;
			for (int i = 0; i < HDR_LEN; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (byte_we) begin
			if (is_term) begin
				run_q <= (run_q == 2'd2) ? 2'd0 : run_q + 2'd1;
			end else if (run_q != 2'd0) begin
				// A broken terminator run drops the byte.
				run_q <= 2'd0;
			end else if (store) begin
				fill_q <= fill_q + FW'(1);
				if (fill_q < FW'(HDR_LEN)) begin
					hdr_q[fill_q[2:0]] <= rx_byte;
				end
			end
		end
	end

	// Entries at or beyond the fill count read as zero, so the memory is never swept.
	always_ff @(posedge clk) begin
		if (store) begin
			mem[fill_q[BW-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[rd_addr];
		rd_ok_q   <= FW'(rd_addr) < fill_q;
	end

	assign rd_char = rd_ok_q ? rd_data_q : 8'h00;
	assign hdr     = '{head: hdr_q[0], b1: hdr_q[1], b2: hdr_q[2], b3: hdr_q[3], b4: hdr_q[4]};

	`DRFD_ASSERT(a_fill_bound, fill_q <= FW'(FRAME_BYTES))

endmodule

### sv/drfd_obj_table.sv
// Object table memory with its registration counter and a registered read port.
// Depends on drfd_pkg and the assertion macro header.
`include "display_reply_frame_decoder_unit_assert.svh"

module drfd_obj_table #(
	parameter int TABLE_DEPTH = 64,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             reg_we,
	input  drfd_pkg::entry_t entry_in,
	input  logic [IW-1:0]    rd_addr,
	output drfd_pkg::entry_t entry_rd,
	output logic [CW-1:0]    count,
	output logic             reg_ok
);

	drfd_pkg::entry_t mem [TABLE_DEPTH];
	drfd_pkg::entry_t rd_q;
	logic [CW-1:0]    count_q;

	assign reg_ok = count_q < CW'(TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (reg_we && reg_ok) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (reg_we && reg_ok) begin
			mem[count_q[IW-1:0]] <= entry_in;
		end
		rd_q <= mem[rd_addr];
	end

	assign entry_rd = rd_q;
	assign count    = count_q;

	`DRFD_ASSERT(a_count_bound, count_q <= CW'(TABLE_DEPTH))
	`DRFD_ASSERT(a_full_holds, (reg_we && !reg_ok) |=> $stable(count_q))

endmodule

### sv/display_reply_frame_decoder_unit.sv
// Reply frame decoder: a plain byte is taken in the idle state; a registration goes on
// to EMIT, its answer registered in the pending result and then the output register.
// A frame end goes through FINISH, then compares table entries (touch) or reads characters
// (string). The single table compare and read port bound the rate; output stall holds it.
// Asynchronous reset clears control state; no clearing pass, memories stay as they were.
// Depends on drfd_pkg, drfd_frame_buf, drfd_obj_table and the assertion macro header.
`include "display_reply_frame_decoder_unit_assert.svh"

module display_reply_frame_decoder_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int FRAME_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  obj_page,
	input  logic [7:0]  obj_component,
	input  logic        obj_has_push,
	input  logic        obj_has_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic        accepted,
	output logic        found,
	output logic [1:0]  touch_action,
	output logic [5:0]  object_index,
	output logic [7:0]  page,
	output logic [7:0]  component,
	output logic [7:0]  event_code,
	output logic [31:0] number,
	output logic [7:0]  text_char,
	output logic        last
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int BW = $clog2(FRAME_BYTES);

	// The sequencer: IDLE takes transactions, FINISH decodes the head byte,
	// WALK compares one table entry a cycle, TEXT reads one character a cycle unless
	// a held one cannot leave, EMIT waits for the output register to take the pending result.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FINISH,
		ST_WALK,
		ST_TEXT,
		ST_EMIT
	} state_t;

	state_t            state_q;
	drfd_pkg::result_t res_q;
	drfd_pkg::result_t res_d;
	drfd_pkg::result_t out_q;
	logic              out_valid_q;
	logic [IW-1:0]     idx_q;
	logic [BW-1:0]     str_idx_q;
	logic [4:0]        nchar_q;
	logic              held_q;

	logic              in_acc;
	logic              reg_we;
	logic              byte_we;
	logic              out_free;
	logic              out_load;
	logic              frame_clear;
	logic              frame_done;
	logic              text_go;
	logic              text_end;
	logic              walk_end;
	logic              match;
	logic [IW-1:0]     tbl_raddr;
	logic [BW-1:0]     buf_raddr;
	logic [7:0]        cur_char;
	logic [CW-1:0]     obj_count;
	logic              reg_ok;
	drfd_pkg::hdr_t    hdr;
	drfd_pkg::entry_t  entry_in;
	drfd_pkg::entry_t  entry_rd;

	// Transactions are taken only in the idle state; the output register lets
	// a new one in while an earlier result still waits downstream.
	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign reg_we   = in_acc && command;
	assign byte_we  = in_acc && !command;
	assign out_free = !out_valid_q || !out_stall;

	assign entry_in = '{page: obj_page, component: obj_component,
		push: obj_has_push, pop: obj_has_pop};

	drfd_frame_buf #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_we    (byte_we),
		.rx_byte    (rx_byte),
		.frame_clear(frame_clear),
		.rd_addr    (buf_raddr),
		.frame_done (frame_done),
		.hdr        (hdr),
		.rd_char    (cur_char)
	);

	drfd_obj_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.reg_we  (reg_we),
		.entry_in(entry_in),
		.rd_addr (tbl_raddr),
		.entry_rd(entry_rd),
		.count   (obj_count),
		.reg_ok  (reg_ok)
	);

	// The shared compare unit: one table entry against the touch key.
	assign match    = entry_rd.page == res_q.page && entry_rd.component == res_q.component;
	assign walk_end = CW'(idx_q) + CW'(1) == obj_count;

	// A string ends at the character limit or at the last buffer slot.
	assign text_end = (nchar_q + 5'd1 == drfd_pkg::MAX_TEXT) ||
		(str_idx_q == BW'(FRAME_BYTES - 1));

	always_comb begin
		out_load    = 1'b0;
		frame_clear = 1'b0;
		text_go     = 1'b0;
		tbl_raddr   = '0;
		buf_raddr   = BW'(1);
		case (state_q)
			ST_FINISH: begin
				if (!(hdr.head inside {drfd_pkg::HEAD_TOUCH, drfd_pkg::HEAD_PAGE,
						drfd_pkg::HEAD_STRING, drfd_pkg::HEAD_NUMBER,
						drfd_pkg::HEAD_DONE})) begin
					frame_clear = 1'b1;
				end
			end
			ST_WALK: begin
				tbl_raddr = idx_q + IW'(1);
			end
			ST_TEXT: begin
				// Keep the read address while a held character cannot leave.
				buf_raddr = str_idx_q;
				if (cur_char != 8'h00 && !(held_q && !out_free)) begin
					text_go  = 1'b1;
					out_load = held_q;
					if (!text_end) begin
						buf_raddr = str_idx_q + BW'(1);
					end
				end
			end
			ST_EMIT: begin
				out_load    = out_free;
				frame_clear = out_free && res_q.kind != drfd_pkg::KIND_REG;
			end
			default: begin
			end
		endcase
	end

	// Next value of the pending result, built up field by field.
	always_comb begin
		res_d = res_q;
		case (state_q)
			ST_IDLE: begin
				if (reg_we) begin
					res_d              = '0;
					res_d.kind         = drfd_pkg::KIND_REG;
					res_d.accepted     = reg_ok;
					res_d.object_index = reg_ok ? 6'(obj_count) : 6'd0;
					res_d.last         = 1'b1;
				end
			end
			ST_FINISH: begin
				res_d      = '0;
				res_d.last = 1'b1;
				case (hdr.head)
					drfd_pkg::HEAD_TOUCH: begin
						res_d.kind       = drfd_pkg::KIND_TOUCH;
						res_d.page       = hdr.b1;
						res_d.component  = hdr.b2;
						res_d.event_code = hdr.b3;
					end
					drfd_pkg::HEAD_PAGE: begin
						res_d.kind = drfd_pkg::KIND_PAGE;
						res_d.page = hdr.b1;
					end
					drfd_pkg::HEAD_STRING: begin
						res_d.kind = drfd_pkg::KIND_TEXT;
						res_d.last = 1'b0;
					end
					drfd_pkg::HEAD_NUMBER: begin
						res_d.kind   = drfd_pkg::KIND_NUM;
						res_d.number = {hdr.b4, hdr.b3, hdr.b2, hdr.b1};
					end
					drfd_pkg::HEAD_DONE: begin
						res_d.kind = drfd_pkg::KIND_DONE;
					end
					default: begin
					end
				endcase
			end
			ST_WALK: begin
				if (match) begin
					res_d.found        = 1'b1;
					res_d.object_index = 6'(idx_q);
					if (res_q.event_code == drfd_pkg::EV_PUSH && entry_rd.push) begin
						res_d.touch_action = drfd_pkg::ACT_PUSH;
					end else if (res_q.event_code == drfd_pkg::EV_RELEASE &&
							entry_rd.pop) begin
						res_d.touch_action = drfd_pkg::ACT_POP;
					end
				end
			end
			ST_TEXT: begin
				// One character is held back so that the last one can be marked.
				if (cur_char == 8'h00) begin
					res_d.last = 1'b1;
				end else if (text_go) begin
					res_d.text_char = cur_char;
					res_d.last      = text_end;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			str_idx_q   <= '0;
			nchar_q     <= '0;
			held_q      <= 1'b0;
		end else begin
			res_q <= res_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (reg_we) begin
						state_q <= ST_EMIT;
					end else if (frame_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					idx_q     <= '0;
					str_idx_q <= BW'(1);
					nchar_q   <= '0;
					held_q    <= 1'b0;
					case (hdr.head)
						drfd_pkg::HEAD_TOUCH: begin
							state_q <= (obj_count == '0) ? ST_EMIT : ST_WALK;
						end
						drfd_pkg::HEAD_PAGE, drfd_pkg::HEAD_NUMBER,
						drfd_pkg::HEAD_DONE: begin
							state_q <= ST_EMIT;
						end
						drfd_pkg::HEAD_STRING: begin
							state_q <= ST_TEXT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_WALK: begin
					if (match || walk_end) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_TEXT: begin
					if (cur_char == 8'h00) begin
						state_q <= ST_EMIT;
					end else if (text_go) begin
						held_q  <= 1'b1;
						nchar_q <= nchar_q + 5'd1;
						if (text_end) begin
							state_q <= ST_EMIT;
						end else begin
							str_idx_q <= str_idx_q + BW'(1);
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign accepted     = out_q.accepted;
	assign found        = out_q.found;
	assign touch_action = out_q.touch_action;
	assign object_index = out_q.object_index;
	assign page         = out_q.page;
	assign component    = out_q.component;
	assign event_code   = out_q.event_code;
	assign number       = out_q.number;
	assign text_char    = out_q.text_char;
	assign last         = out_q.last;

	`DRFD_ASSERT(a_reg_to_emit, reg_we |=> state_q == ST_EMIT)
	`DRFD_ASSERT_IMP(a_walk_in_range, state_q == ST_WALK, CW'(idx_q) < obj_count)
	`DRFD_ASSERT_IMP(a_text_limit, state_q == ST_TEXT, nchar_q < drfd_pkg::MAX_TEXT)
	`DRFD_ASSERT_IMP(a_no_overwrite, out_load, out_free)

endmodule

### tb/sv/tb_display_reply_frame_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the display reply frame decoder.
// It drives serial bytes and object registrations, predicts every reply with a local
// decoder model and checks each one. It depends on drfd_pkg and the decoder RTL.

module tb_display_reply_frame_decoder_unit;

	localparam int TABLE_DEPTH  = 64;
	localparam int FRAME_BYTES  = 32;
	localparam int CLK_PERIOD   = 12;
	localparam int ITEM_TARGET  = 470;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_LIMIT = 10;
	localparam int TIMEOUT_NS   = 10_000_000;
	localparam logic [7:0] NUL_CHAR = 8'h00;

	// One input transaction, laid out in the order of the block's input ports.
	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
		logic [7:0] obj_page;
		logic [7:0] obj_component;
		logic       obj_has_push;
		logic       obj_has_pop;
	} item_t;

	// One row of the directed table. Where has_want is set, the row's reply is typed
	// in by hand and replaces whatever the decoder model would have predicted.
	typedef struct {
		item_t             item;
		bit                has_want;
		drfd_pkg::result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [7:0]  rx_byte;
	logic [7:0]  obj_page;
	logic [7:0]  obj_component;
	logic        obj_has_push;
	logic        obj_has_pop;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic        accepted;
	logic        found;
	logic [1:0]  touch_action;
	logic [5:0]  object_index;
	logic [7:0]  page;
	logic [7:0]  component;
	logic [7:0]  event_code;
	logic [31:0] number;
	logic [7:0]  text_char;
	logic        last;

	display_reply_frame_decoder_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.rx_byte(rx_byte),
		.obj_page(obj_page),
		.obj_component(obj_component),
		.obj_has_push(obj_has_push),
		.obj_has_pop(obj_has_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.accepted(accepted),
		.found(found),
		.touch_action(touch_action),
		.object_index(object_index),
		.page(page),
		.component(component),
		.event_code(event_code),
		.number(number),
		.text_char(text_char),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decoder model state: the frame being collected, the run of 0xFF bytes and the
	// object table. Only the stimulus process writes it, at the moment an input
	// transaction is accepted.
	logic [7:0]       frame_bytes [FRAME_BYTES];
	int               frame_fill = 0;
	int               ff_run = 0;
	drfd_pkg::entry_t obj_table [TABLE_DEPTH];
	int               obj_count = 0;

	// Replies still owed by the block, oldest first.
	drfd_pkg::result_t expected_results [$];

	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int regs_refused = 0;

	// Shared between the two sides. The sender bumps holds_requested to make the
	// receiver hold off for a long stretch; steady_flow switches off idling on both.
	int holds_requested = 0;
	bit steady_flow = 1'b0;

	function automatic drfd_pkg::result_t blank_result(drfd_pkg::kind_t k);
		drfd_pkg::result_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	// A single reply that closes its transaction, for the hand-typed table rows.
	function automatic drfd_pkg::result_t final_result(drfd_pkg::kind_t k, logic acc,
			logic [5:0] idx);
		drfd_pkg::result_t r;
		r = blank_result(k);
		r.accepted = acc;
		r.object_index = idx;
		r.last = 1'b1;
		return r;
	endfunction

	// Acts on the head byte of a completed frame, then clears the frame.
	function automatic void close_frame();
		drfd_pkg::result_t r;
		int n;
		n = 0;
		case (frame_bytes[0])
			drfd_pkg::HEAD_TOUCH: begin
				r = blank_result(drfd_pkg::KIND_TOUCH);
				r.page = frame_bytes[1];
				r.component = frame_bytes[2];
				r.event_code = frame_bytes[3];
				// The first object that matches both page and component wins.
				for (int i = 0; i < obj_count && !r.found; i++) begin
					if (obj_table[i].page == frame_bytes[1] &&
							obj_table[i].component == frame_bytes[2]) begin
						r.found = 1'b1;
						r.object_index = i[5:0];
						if (frame_bytes[3] == drfd_pkg::EV_PUSH && obj_table[i].push)
							r.touch_action = drfd_pkg::ACT_PUSH;
						else if (frame_bytes[3] == drfd_pkg::EV_RELEASE &&
								obj_table[i].pop)
							r.touch_action = drfd_pkg::ACT_POP;
					end
				end
				expected_results.push_back(r);
			end
			drfd_pkg::HEAD_PAGE: begin
				r = blank_result(drfd_pkg::KIND_PAGE);
				r.page = frame_bytes[1];
				expected_results.push_back(r);
			end
			drfd_pkg::HEAD_STRING: begin
				for (int i = 1; i < FRAME_BYTES && n < drfd_pkg::MAX_TEXT &&
						frame_bytes[i] != NUL_CHAR; i++) begin
					r = blank_result(drfd_pkg::KIND_TEXT);
					r.text_char = frame_bytes[i];
					expected_results.push_back(r);
					n++;
				end
				// An empty string still answers with one zero character.
				if (n == 0)
					expected_results.push_back(blank_result(drfd_pkg::KIND_TEXT));
			end
			drfd_pkg::HEAD_NUMBER: begin
				r = blank_result(drfd_pkg::KIND_NUM);
				r.number = {frame_bytes[4], frame_bytes[3], frame_bytes[2], frame_bytes[1]};
				expected_results.push_back(r);
			end
			drfd_pkg::HEAD_DONE: expected_results.push_back(blank_result(drfd_pkg::KIND_DONE));
			default: ;
		endcase
		foreach (frame_bytes[i])
			frame_bytes[i] = NUL_CHAR;
		frame_fill = 0;
		ff_run = 0;
	endfunction

	// Updates the model for one accepted transaction and queues the replies it causes.
	function automatic void predict_item(item_t it);
		drfd_pkg::result_t r;
		int n0;
		n0 = expected_results.size();
		if (it.command) begin
			r = blank_result(drfd_pkg::KIND_REG);
			if (obj_count < TABLE_DEPTH) begin
				obj_table[obj_count] = '{page: it.obj_page, component: it.obj_component,
					push: it.obj_has_push, pop: it.obj_has_pop};
				r.accepted = 1'b1;
				r.object_index = obj_count[5:0];
				obj_count++;
			end else begin
				regs_refused++;
			end
			expected_results.push_back(r);
		end else if (it.rx_byte == drfd_pkg::TERM_BYTE) begin
			ff_run++;
			if (ff_run >= 3)
				close_frame();
		end else if (ff_run != 0) begin
			// A broken terminator: the byte is dropped and the run starts over.
			ff_run = 0;
		end else if (frame_fill < FRAME_BYTES) begin
			frame_bytes[frame_fill] = it.rx_byte;
			frame_fill++;
		end
		if (expected_results.size() > n0) begin
			r = expected_results.pop_back();
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endfunction

	function automatic string describe(drfd_pkg::result_t r);
		return $sformatf({"kind=%0d acc=%0d found=%0d act=%0d idx=%0d page=%h comp=%h ",
			"ev=%h num=%h char=%h last=%0d"}, r.kind, r.accepted, r.found, r.touch_action,
			r.object_index, r.page, r.component, r.event_code, r.number, r.text_char, r.last);
	endfunction

	function automatic void report_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: %s", $time, msg);
	endfunction

	// Compares one accepted reply with the oldest one still owed, field by field.
	function automatic void check_result();
		drfd_pkg::result_t got;
		drfd_pkg::result_t want;
		string bad;
		got = '{kind: drfd_pkg::kind_t'(kind), accepted: accepted, found: found,
			touch_action: touch_action, object_index: object_index, page: page,
			component: component, event_code: event_code, number: number,
			text_char: text_char, last: last};
		results_seen++;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("reply with nothing owed: %s", describe(got)));
			return;
		end
		want = expected_results.pop_front();
		bad = "";
		if (got.kind !== want.kind) bad = {bad, " kind"};
		if (got.accepted !== want.accepted) bad = {bad, " accepted"};
		if (got.found !== want.found) bad = {bad, " found"};
		if (got.touch_action !== want.touch_action) bad = {bad, " touch_action"};
		if (got.object_index !== want.object_index) bad = {bad, " object_index"};
		if (got.page !== want.page) bad = {bad, " page"};
		if (got.component !== want.component) bad = {bad, " component"};
		if (got.event_code !== want.event_code) bad = {bad, " event_code"};
		if (got.number !== want.number) bad = {bad, " number"};
		if (got.text_char !== want.text_char) bad = {bad, " text_char"};
		if (got.last !== want.last) bad = {bad, " last"};
		if (bad != "")
			report_mismatch($sformatf("reply %0d differs in%s\n  expected %s\n  actual   %s",
				results_seen, bad, describe(want), describe(got)));
	endfunction

	// Output monitor. A reply transaction completes on a rising edge where out_valid
	// is high and out_stall is low; out_stall only moves on falling edges.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
	end

	// Receiver side. Before each reply it may stall at random, never in steady-flow
	// stretches, and on request it holds off for a long stretch so the decoder backs up.
	initial begin : receiver
		int wait_n;
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (holds_done < holds_requested) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			wait_n = steady_flow ? 0 : $urandom_range(0, 4);
			if (wait_n != 0) begin
				out_stall = 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Sends one input transaction: an optional idle gap, then the payload is held with
	// in_valid high until the decoder accepts it. Called and left at a falling edge.
	// The model is updated at the accepting edge, so the owed replies are always in
	// place before the first of them can appear.
	task automatic send_item(item_t it, bit has_want, drfd_pkg::result_t want);
		int gap;
		int n0;
		gap = steady_flow ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{command, rx_byte, obj_page, obj_component, obj_has_push, obj_has_pop} = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		n0 = expected_results.size();
		predict_item(it);
		if (has_want) begin
			while (expected_results.size() > n0)
				void'(expected_results.pop_back());
			expected_results.push_back(want);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// A received byte; the registration fields ride along with random content.
	task automatic send_byte(logic [7:0] b);
		item_t it;
		it.command = 1'b0;
		it.rx_byte = b;
		it.obj_page = 8'($urandom);
		it.obj_component = 8'($urandom);
		it.obj_has_push = 1'($urandom);
		it.obj_has_pop = 1'($urandom);
		send_item(it, 1'b0, '0);
	endtask

	// A registration; the byte field carries random content.
	task automatic send_reg(logic [7:0] pg, logic [7:0] cp, logic psh, logic pop);
		item_t it;
		it = '{command: 1'b1, rx_byte: 8'($urandom), obj_page: pg, obj_component: cp,
			obj_has_push: psh, obj_has_pop: pop};
		send_item(it, 1'b0, '0);
	endtask

	task automatic send_frame_end();
		repeat (3) send_byte(drfd_pkg::TERM_BYTE);
	endtask

	// Payload byte that cannot be mistaken for part of a terminator.
	function automatic logic [7:0] data_byte();
		return 8'($urandom_range(0, 254));
	endfunction

	// String frame of len characters; with cut_short one of them may become a zero,
	// which ends the text early.
	task automatic send_text_frame(int len, bit cut_short);
		int cut;
		cut = cut_short ? $urandom_range(0, len) : -1;
		send_byte(drfd_pkg::HEAD_STRING);
		for (int i = 0; i < len; i++)
			send_byte(i == cut ? NUL_CHAR : 8'($urandom_range(1, 254)));
		send_frame_end();
	endtask

	// Parks the sender until every owed reply has come back.
	task automatic drain_outputs();
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One random sequence: mostly well-formed frames with random content, else registrations,
	// random-head or empty frames, broken terminators, overlong frames or loose noise bytes.
	task automatic send_random_sequence();
		int pick;
		int n;
		int slot;
		logic [7:0] pg;
		logic [7:0] cp;
		logic [7:0] ev;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// A burst of registrations, some repeating a known page and component so
			// that a later touch must pick the first of several matches.
			repeat ($urandom_range(1, 6)) begin
				if (obj_count > 0 && $urandom_range(0, 9) < 4) begin
					slot = $urandom_range(0, obj_count - 1);
					send_reg(obj_table[slot].page, obj_table[slot].component,
						1'($urandom), 1'($urandom));
				end else begin
					send_reg(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
				end
			end
		end else if (pick < 34) begin
			// Touch frames mostly aim at a registered object.
			if (obj_count > 0 && $urandom_range(0, 4) != 0) begin
				slot = $urandom_range(0, obj_count - 1);
				pg = obj_table[slot].page;
				cp = obj_table[slot].component;
			end else begin
				pg = data_byte();
				cp = data_byte();
			end
			if (pg == drfd_pkg::TERM_BYTE) pg = data_byte();
			if (cp == drfd_pkg::TERM_BYTE) cp = data_byte();
			n = $urandom_range(0, 9);
			ev = n < 4 ? drfd_pkg::EV_PUSH : (n < 8 ? drfd_pkg::EV_RELEASE : data_byte());
			send_byte(drfd_pkg::HEAD_TOUCH);
			send_byte(pg);
			send_byte(cp);
			// Now and then the event byte is missing and reads as a release.
			if ($urandom_range(0, 9) != 0)
				send_byte(ev);
			send_frame_end();
		end else if (pick < 44) begin
			send_byte(drfd_pkg::HEAD_PAGE);
			send_byte(data_byte());
			repeat ($urandom_range(0, 9) == 0 ? 3 : 0) send_byte(data_byte());
			send_frame_end();
		end else if (pick < 60) begin
			// Short strings, and now and then a long one that may run past the frame buffer.
			n = $urandom_range(0, 6) == 0 ? $urandom_range(28, 40) : $urandom_range(0, 8);
			send_text_frame(n, $urandom_range(0, 5) == 0);
		end else if (pick < 72) begin
			n = $urandom_range(0, 9);
			n = n == 0 ? 2 : (n == 1 ? 7 : 4);
			send_byte(drfd_pkg::HEAD_NUMBER);
			repeat (n) send_byte(data_byte());
			send_frame_end();
		end else if (pick < 78) begin
			send_byte(drfd_pkg::HEAD_DONE);
			send_frame_end();
		end else if (pick < 84) begin
			// Any head byte at all; most of them call for no reply.
			send_byte(8'($urandom));
			repeat ($urandom_range(0, 3)) send_byte(data_byte());
			send_frame_end();
		end else if (pick < 88) begin
			send_frame_end();
		end else if (pick < 94) begin
			// One or two 0xFF inside a frame followed by a byte that gets dropped.
			send_byte($urandom_range(0, 1) ? drfd_pkg::HEAD_PAGE : drfd_pkg::HEAD_NUMBER);
			send_byte(data_byte());
			repeat ($urandom_range(1, 2)) send_byte(drfd_pkg::TERM_BYTE);
			send_byte(data_byte());
			repeat (4) send_byte(data_byte());
			send_frame_end();
		end else begin
			// Loose bytes with plenty of 0xFF; they leave the next frame disturbed.
			repeat ($urandom_range(1, 5))
				send_byte($urandom_range(0, 2) == 0 ? drfd_pkg::TERM_BYTE : 8'($urandom));
		end
	endtask

	function automatic stim_row_t byte_row(logic [7:0] b);
		stim_row_t row;
		row.item = '0;
		row.item.rx_byte = b;
		row.has_want = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t reg_row(logic [7:0] pg, logic [7:0] cp, logic psh,
			logic pop);
		stim_row_t row;
		row.item = '{command: 1'b1, rx_byte: 8'h00, obj_page: pg, obj_component: cp,
			obj_has_push: psh, obj_has_pop: pop};
		row.has_want = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t with_result(stim_row_t row, drfd_pkg::result_t want);
		row.has_want = 1'b1;
		row.want = want;
		return row;
	endfunction

	initial begin : stimulus
		stim_row_t stim_table [$];
		bit table_filled;
		int next_reflow;
		int next_drain;
		table_filled = 1'b0;
		next_reflow = 40;
		next_drain = 100;
		foreach (frame_bytes[i])
			frame_bytes[i] = NUL_CHAR;
		foreach (obj_table[i])
			obj_table[i] = '0;

		// Every input is known from time zero; reset is held from the start, released on a
		// falling edge and never asserted again.
		arst_n = 1'b0;
		in_valid = 1'b0;
		{command, rx_byte, obj_page, obj_component, obj_has_push, obj_has_pop} = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. Registrations right after reset fill slots 0, 1 and 2, with
		// the extremes of the page and component fields.
		stim_table.push_back(with_result(reg_row(8'h00, 8'h00, 1'b1, 1'b0),
			final_result(drfd_pkg::KIND_REG, 1'b1, 6'd0)));
		stim_table.push_back(with_result(reg_row(8'hFE, 8'h80, 1'b0, 1'b1),
			final_result(drfd_pkg::KIND_REG, 1'b1, 6'd1)));
		stim_table.push_back(with_result(reg_row(8'hFF, 8'hFF, 1'b1, 1'b1),
			final_result(drfd_pkg::KIND_REG, 1'b1, 6'd2)));
		// An empty frame: the head reads as zero, so no reply at all.
		repeat (3) stim_table.push_back(byte_row(drfd_pkg::TERM_BYTE));
		// Release touch on page FE, component 80. The lone 0xFF before 11 is a broken
		// terminator, so 11 is dropped and the frame stays intact.
		stim_table.push_back(byte_row(drfd_pkg::HEAD_TOUCH));
		stim_table.push_back(byte_row(8'hFE));
		stim_table.push_back(byte_row(drfd_pkg::TERM_BYTE));
		stim_table.push_back(byte_row(8'h11));
		stim_table.push_back(byte_row(8'h80));
		stim_table.push_back(byte_row(drfd_pkg::EV_RELEASE));
		repeat (3) stim_table.push_back(byte_row(drfd_pkg::TERM_BYTE));
		// An empty string answers with a single zero character.
		stim_table.push_back(byte_row(drfd_pkg::HEAD_STRING));
		stim_table.push_back(byte_row(NUL_CHAR));
		repeat (2) stim_table.push_back(byte_row(drfd_pkg::TERM_BYTE));
		stim_table.push_back(with_result(byte_row(drfd_pkg::TERM_BYTE),
			final_result(drfd_pkg::KIND_TEXT, 1'b0, 6'd0)));
		// Command finished.
		stim_table.push_back(byte_row(drfd_pkg::HEAD_DONE));
		repeat (2) stim_table.push_back(byte_row(drfd_pkg::TERM_BYTE));
		stim_table.push_back(with_result(byte_row(drfd_pkg::TERM_BYTE),
			final_result(drfd_pkg::KIND_DONE, 1'b0, 6'd0)));

		foreach (stim_table[i])
			send_item(stim_table[i].item, stim_table[i].has_want, stim_table[i].want);
		drain_outputs();

		// Random part.
		while (items_sent < ITEM_TARGET) begin
			// Every 40 transactions or so, maybe switch to a stretch without idling.
			if (items_sent >= next_reflow) begin
				steady_flow = $urandom_range(0, 3) == 0;
				next_reflow += 40;
			end
			// Halfway through, fill the object table and knock on it a few more
			// times while it is full.
			if (!table_filled && items_sent >= ITEM_TARGET / 2) begin
				while (obj_count < TABLE_DEPTH)
					send_reg(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
				repeat (3) send_reg(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
				table_filled = 1'b1;
			end
			// Twice in the run the receiver holds off for a long stretch while the sender
			// keeps going with a full-length string and more frames behind it, so the
			// decoder backs up and has to stall its input.
			if (holds_requested < 2 && items_sent >= (holds_requested == 0 ? 120 : 360)) begin
				holds_requested++;
				steady_flow = 1'b1;
				send_text_frame(drfd_pkg::MAX_TEXT + 3, 1'b0);
				repeat (3) send_random_sequence();
				steady_flow = 1'b0;
			end
			if (items_sent >= next_drain) begin
				drain_outputs();
				next_drain += 100;
			end
			send_random_sequence();
		end

		// Wrap up: wait for every owed reply, then watch a while longer for strays.
		drain_outputs();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d input transactions and %0d replies, %0d registrations",
			items_sent, results_seen, obj_count + regs_refused);
		$display("(%0d refused on a full table), %0d long output hold-offs, %0d mismatches.",
			regs_refused, holds_requested, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timed out with %0d replies still owed.", expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
